// ===== src/gsp_pkg.sv =====
// Shared types, constants and lookup tables for the gas sensor ppm estimator.
// No dependencies; every other file imports this package.
`default_nettype none

package gsp_pkg;

	localparam int ADC_BITS          = 10;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int LIDX              = $clog2(LOG_TABLE_ENTRIES);
	localparam int SAMPLE_W          = 10;
	localparam int NUM_W             = 16 + ADC_BITS;
	localparam int DIV_W             = 64;
	localparam int DVS_W             = 32;
	localparam int IT_W              = 7;
	localparam int SUM_W             = 52;
	localparam int CNT_W             = 20;
	localparam int LOG_LF            = 31 - LIDX;
	localparam int EXP_LF            = 16 - LIDX;

	localparam logic [ADC_BITS-1:0] ADC_FULL    = '1;
	localparam logic [31:0]         LOG10_2_Q32 = 32'h4D10_4D42;
	localparam logic [63:0]         MAG_CAP     = 64'h4000_0000_0000_0000;
	localparam logic [31:0]         DIVISOR_CO  = 32'd10;
	localparam logic [31:0]         DIVISOR_O3  = 32'd1000;

	localparam logic [1:0] MODE_GENERIC = 2'd0;
	localparam logic [1:0] MODE_CO2     = 2'd1;
	localparam logic [1:0] MODE_CO      = 2'd2;
	localparam logic [1:0] MODE_O3      = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_SMP = 2'd1;
	localparam logic [1:0] ST_NO_CAL   = 2'd2;
	localparam logic [1:0] ST_BAD_BASE = 2'd3;

	localparam logic [2:0] REG_SPA  = 3'd0;
	localparam logic [2:0] REG_RL   = 3'd1;
	localparam logic [2:0] REG_CAR  = 3'd2;
	localparam logic [2:0] REG_A    = 3'd3;
	localparam logic [2:0] REG_B    = 3'd4;
	localparam logic [2:0] REG_MODE = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_RS, S_ADD, S_CHK, S_AVG, S_RO, S_RAT, S_NORM, S_LG1, S_LG2,
		S_CO2, S_EXP1, S_EXP2, S_EXP3, S_SCL, S_DIV, S_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [IT_W-1:0] iters;
	} div_ctl_t;

	typedef struct packed {
		logic            start;
		logic            left;
		logic [IT_W-1:0] count;
	} scl_ctl_t;

	typedef logic [31:0] tab_t [0:LOG_TABLE_ENTRIES];

	// Fractional log2 of a Q2.30 mantissa in [1,2] by repeated squaring.
	function automatic logic [31:0] frac_log2(logic [31:0] m, int bits);
		logic [63:0] y;
		logic [31:0] r;
		y = 64'(m);
		r = '0;
		if (m >= 32'h8000_0000) begin
			return 32'(64'd1 << bits);
		end
		for (int k = 0; k < bits; k++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= 64'h8000_0000) begin
				y = y >> 1;
				r = r | 32'd1;
			end
		end
		return r;
	endfunction

	function automatic tab_t build_lg();
		tab_t        t;
		logic [31:0] m;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			m = 32'h4000_0000 + 32'((64'(i) << 30) / LOG_TABLE_ENTRIES);
			t[i] = (frac_log2(m, 18) + 32'd2) >> 2;
		end
		return t;
	endfunction

	function automatic tab_t build_ex();
		tab_t        t;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		logic [31:0] target;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			target = 32'((64'(i) << 24) / LOG_TABLE_ENTRIES);
			lo = 32'h4000_0000;
			hi = 32'h8000_0000;
			if (i == LOG_TABLE_ENTRIES) begin
				t[i] = hi;
			end else begin
				while (lo < hi) begin
					mid = lo + (hi - lo + 32'd1) / 2;
					if (frac_log2(mid, 24) <= target) begin
						lo = mid;
					end else begin
						hi = mid - 32'd1;
					end
				end
				t[i] = lo;
			end
		end
		return t;
	endfunction

	localparam tab_t LG_TAB = build_lg();
	localparam tab_t EX_TAB = build_ex();

endpackage

`default_nettype wire

// ===== src/gsp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gsp_pkg for widths and the control struct.
`default_nettype none

module gsp_div
	import gsp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [DIV_W-1:0] quotient,
	output logic                  done
);

	// The dividend is left aligned; it shifts out at the top while quotient
	// bits shift in at the bottom of the same register.
	logic [DIV_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [IT_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.iters;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - IT_W'(1);
			busy_q <= cnt_q != IT_W'(1);
			done_q <= cnt_q == IT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== src/gsp_scale.sv =====
// Serial power-of-two scaler: shifts one bit per cycle, saturating left shifts.
// Depends on gsp_pkg for the saturation cap and the control struct.
`default_nettype none

module gsp_scale
	import gsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire scl_ctl_t    ctl,
	input  wire logic [63:0] din,
	output logic      [63:0] dout,
	output logic             done
);

	logic [63:0]     v_q;
	logic [IT_W-1:0] cnt_q;
	logic            left_q;
	logic            busy_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= ctl.count != '0;
			done_q <= ctl.count == '0;
			cnt_q  <= ctl.count;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - IT_W'(1);
			busy_q <= cnt_q != IT_W'(1);
			done_q <= cnt_q == IT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Once a left shift passes the cap it sticks there.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q    <= din;
			left_q <= ctl.left;
		end else if (busy_q) begin
			if (left_q) begin
				v_q <= (v_q > (MAG_CAP >> 1)) ? MAG_CAP : (v_q << 1);
			end else begin
				v_q <= v_q >> 1;
			end
		end
	end

	assign dout = v_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== src/gas_sensor_ppm_estimator_core.sv =====
// A sample that does not end a run goes from transfer through S_RS (skipped for a zero sample),
// S_ADD and S_CHK back to S_IDLE. A run end adds the average division, the Ro or ratio division,
// up to two normalizations, the log and exp steps, the power-of-two scaling and the mode division.
// Samples do not overlap: in_ready is high only in S_IDLE, and the bit-serial divider is shared.
// Reset (arst_n low) restores the register defaults and clears the run and the reference.
// The result register frees the input side: a new sample transfers while a result waits.
`default_nettype none

module gas_sensor_ppm_estimator_core
	import gsp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                cmd,
	input  wire logic [SAMPLE_W-1:0] sample,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     run_kind,
	output logic [31:0]              mean_resistance,
	output logic [31:0]              resistance_ratio,
	output logic signed [31:0]       concentration,
	output logic [1:0]               status
);

	// Configuration registers.
	logic [9:0]         spa_q;
	logic [15:0]        rl_q;
	logic [15:0]        car_q;
	logic signed [31:0] ca_q;
	logic signed [15:0] cb_q;
	logic [1:0]         mode_q;

	// Run state that the model keeps between samples.
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] target_q;
	logic             cal_q;
	logic             sat_q;
	logic [31:0]      ro_q;

	// Working registers of the end-of-run sequence.
	state_t             state_q, state_d;
	logic [31:0]        rs_q;
	logic [31:0]        avg_q;
	logic [31:0]        ratio_q;
	logic [31:0]        conc_q;
	logic [1:0]         stat_q;
	logic [31:0]        x_q;
	logic [4:0]         p_q;
	logic [31:0]        lgl_q;
	logic [31+LOG_LF:0] lgp_q;
	logic signed [31:0] lg_q;
	logic               co2_q;
	logic signed [35:0] e_q;
	logic [31:0]        mant_q;
	logic               shl_q;
	logic [IT_W-1:0]    shc_q;
	logic               out_valid_q;

	// Divider and scaler hookup.
	div_ctl_t         div_ctl;
	logic [DIV_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DIV_W-1:0] div_q;
	logic             div_done;
	scl_ctl_t         scl_ctl;
	logic [63:0]      scl_din;
	logic [63:0]      scl_q;
	logic             scl_done;

	// Sample front end.
	logic [ADC_BITS-1:0] v;
	logic [NUM_W-1:0]    num;
	logic                accept;
	logic                run_clear;
	logic [9:0]          nn;
	logic [15:0]         car_eff;
	logic [31:0]         avg_w;
	logic [31:0]         ro_w;
	logic [31:0]         ratio_w;
	logic [31:0]         mode_div;
	logic [63:0]         scl_cap;
	logic [31:0]         mag_a;

	// Log stage.
	logic [LIDX:0]      lidx;
	logic [31:0]        llo;
	logic [31:0]        lhi;
	logic [31:0]        ldiff;
	logic signed [31:0] pint;
	logic [63:0]        co2_prod;
	logic [31:0]        co2_mag;

	// Exp stage.
	logic signed [47:0] ep;
	logic signed [19:0] en;
	logic [15:0]        ef;
	logic [LIDX:0]      eidx;
	logic [31:0]        elo;
	logic [31:0]        ehi;
	logic [31:0]        ediff;
	logic [31+EXP_LF:0] emp;
	logic signed [20:0] sh_s;
	logic [20:0]        sh_mag;

	// Final sign and saturation.
	logic [63:0] fin_v;
	logic [31:0] fin_conc;

	gsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_q),
		.done     (div_done)
	);

	gsp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scl_ctl),
		.din    (scl_din),
		.dout   (scl_q),
		.done   (scl_done)
	);

	assign v         = sample[ADC_BITS-1:0];
	assign num       = NUM_W'(rl_q) * NUM_W'(ADC_FULL - v);
	assign accept    = in_valid && in_ready;
	assign run_clear = (cnt_q != '0) && (cmd != cal_q);
	assign nn        = (spa_q == '0) ? 10'd1 : spa_q;
	assign car_eff   = (car_q == '0) ? 16'd1 : car_q;
	assign avg_w     = div_q[31:0];
	// The quotient sits in the low bits; anything above bit 31 means saturation.
	assign ro_w      = (div_q[39:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
	assign ratio_w   = (div_q[47:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
	assign scl_cap   = (scl_q > MAG_CAP) ? MAG_CAP : scl_q;
	assign mag_a     = ca_q[31] ? (32'd0 - ca_q) : ca_q;

	always_comb begin
		case (mode_q)
			MODE_CO: mode_div = DIVISOR_CO;
			MODE_O3: mode_div = DIVISOR_O3;
			default: mode_div = 32'd1;
		endcase
	end

	// Log2 of the normalized mantissa: table segment plus linear interpolation.
	assign lidx     = {1'b0, x_q[30 -: LIDX]};
	assign llo      = LG_TAB[lidx];
	assign lhi      = LG_TAB[lidx + (LIDX+1)'(1)];
	assign ldiff    = (lhi > llo) ? (lhi - llo) : 32'd0;
	assign pint     = $signed({27'd0, p_q}) - 32'sd16;
	assign co2_prod = 64'(lg_q[30:0]) * 64'(LOG10_2_Q32);
	assign co2_mag  = (lg_q > 32'sd0) ? co2_prod[63:32] : 32'd0;

	// Exponent split into integer and fraction; 2^fraction from the exp table.
	assign ep     = lg_q * cb_q;
	assign en     = e_q[35:16];
	assign ef     = e_q[15:0];
	assign eidx   = {1'b0, ef[15 -: LIDX]};
	assign elo    = EX_TAB[eidx];
	assign ehi    = EX_TAB[eidx + (LIDX+1)'(1)];
	assign ediff  = (ehi > elo) ? (ehi - elo) : 32'd0;
	assign emp    = (32+EXP_LF)'(ediff) * (32+EXP_LF)'(ef[EXP_LF-1:0]);
	assign sh_s   = 21'sd30 - {en[19], en};
	assign sh_mag = sh_s[20] ? 21'(-sh_s) : 21'(sh_s);

	// The sign of a is applied last, with saturation to the signed range.
	assign fin_v = div_q;
	always_comb begin
		if (ca_q[31]) begin
			fin_conc = 32'd0 - ((fin_v > 64'h8000_0000) ? 32'h8000_0000 : fin_v[31:0]);
		end else begin
			fin_conc = (fin_v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : fin_v[31:0];
		end
	end

	// Next state and unit control.
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.iters = IT_W'(NUM_W);
		div_dvd       = {num, {(DIV_W-NUM_W){1'b0}}};
		div_dvs       = DVS_W'(v);
		scl_ctl.start = 1'b0;
		scl_ctl.left  = shl_q;
		scl_ctl.count = shc_q;
		scl_din       = 64'(mag_a) * 64'(mant_q);
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (v == '0) begin
						state_d = S_ADD;
					end else begin
						div_ctl.start = 1'b1;
						state_d       = S_RS;
					end
				end
			end
			S_RS: begin
				if (div_done) begin
					state_d = S_ADD;
				end
			end
			S_ADD: state_d = S_CHK;
			S_CHK: begin
				if (cnt_q < target_q) begin
					state_d = S_IDLE;
				end else begin
					div_ctl.start = 1'b1;
					div_ctl.iters = IT_W'(SUM_W);
					div_dvd       = {sum_q, {(DIV_W-SUM_W){1'b0}}};
					div_dvs       = DVS_W'(cnt_q);
					state_d       = S_AVG;
				end
			end
			S_AVG: begin
				div_dvd = {avg_w, 32'd0};
				if (div_done) begin
					if (cal_q) begin
						div_ctl.start = 1'b1;
						div_ctl.iters = IT_W'(40);
						div_dvs       = DVS_W'(car_eff);
						state_d       = S_RO;
					end else if (ro_q == '0) begin
						state_d = S_OUT;
					end else begin
						div_ctl.start = 1'b1;
						div_ctl.iters = IT_W'(48);
						div_dvs       = ro_q;
						state_d       = S_RAT;
					end
				end
			end
			S_RO: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_RAT: begin
				if (div_done) begin
					state_d = (ratio_w == '0) ? S_OUT : S_NORM;
				end
			end
			S_NORM: begin
				if (x_q[31]) begin
					state_d = S_LG1;
				end
			end
			S_LG1: state_d = S_LG2;
			S_LG2: state_d = (mode_q == MODE_CO2 && !co2_q) ? S_CO2 : S_EXP1;
			S_CO2: state_d = (co2_mag == '0) ? S_OUT : S_NORM;
			S_EXP1: state_d = S_EXP2;
			S_EXP2: state_d = S_EXP3;
			S_EXP3: begin
				scl_ctl.start = 1'b1;
				state_d       = S_SCL;
			end
			S_SCL: begin
				div_dvd = scl_cap;
				div_dvs = mode_div;
				if (scl_done) begin
					div_ctl.start = 1'b1;
					div_ctl.iters = IT_W'(DIV_W);
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; an index past the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q  <= 10'd100;
			rl_q   <= 16'd256;
			car_q  <= 16'd256;
			ca_q   <= 32'sd65536;
			cb_q   <= 16'sd4096;
			mode_q <= MODE_GENERIC;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPA:  spa_q  <= cfg_data[9:0];
				REG_RL:   rl_q   <= cfg_data[15:0];
				REG_CAR:  car_q  <= cfg_data[15:0];
				REG_A:    ca_q   <= cfg_data;
				REG_B:    cb_q   <= cfg_data[15:0];
				REG_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Run bookkeeping. A sample of the other kind drops the run in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			target_q <= '0;
			cal_q    <= 1'b0;
			sat_q    <= 1'b0;
			ro_q     <= '0;
		end else begin
			if (accept) begin
				if (run_clear) begin
					sum_q <= '0;
					cnt_q <= '0;
				end
				if (run_clear || cnt_q == '0) begin
					cal_q <= cmd;
				end
				sat_q <= (v == '0) || (sat_q && !run_clear);
			end
			if (state_q == S_ADD) begin
				sum_q    <= sum_q + SUM_W'(rs_q);
				cnt_q    <= cnt_q + CNT_W'(1);
				target_q <= cal_q ? (CNT_W'(nn) * CNT_W'(nn)) : CNT_W'(nn);
			end
			if (state_q == S_RO && div_done) begin
				ro_q <= ro_w;
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				sum_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	// Datapath of the end-of-run sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			rs_q <= 32'hFFFF_FFFF;
		end
		if (state_q == S_RS && div_done) begin
			rs_q <= (div_q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
		end
		if (state_q == S_AVG && div_done) begin
			avg_q   <= avg_w;
			ratio_q <= '0;
			conc_q  <= '0;
			stat_q  <= ST_NO_CAL;
		end
		if (state_q == S_RO && div_done) begin
			avg_q  <= ro_w;
			stat_q <= sat_q ? ST_ZERO_SMP : ST_OK;
		end
		if (state_q == S_RAT && div_done) begin
			ratio_q <= ratio_w;
			stat_q  <= ST_BAD_BASE;
			x_q     <= ratio_w;
			p_q     <= 5'd31;
			co2_q   <= 1'b0;
		end
		if (state_q == S_NORM && !x_q[31]) begin
			x_q <= x_q << 1;
			p_q <= p_q - 5'd1;
		end
		if (state_q == S_LG1) begin
			lgl_q <= llo;
			lgp_q <= (32+LOG_LF)'(ldiff) * (32+LOG_LF)'(x_q[LOG_LF-1:0]);
		end
		if (state_q == S_LG2) begin
			lg_q <= (pint <<< 16) + $signed(lgl_q) + $signed(32'(lgp_q >> LOG_LF));
		end
		if (state_q == S_CO2) begin
			x_q   <= co2_mag;
			p_q   <= 5'd31;
			co2_q <= 1'b1;
		end
		if (state_q == S_EXP1) begin
			e_q <= ep[47:12];
		end
		if (state_q == S_EXP2) begin
			mant_q <= elo + 32'(emp >> EXP_LF);
			shl_q  <= sh_s[20];
			shc_q  <= (sh_mag > 21'd64) ? IT_W'(64) : sh_mag[IT_W-1:0];
		end
		if (state_q == S_DIV && div_done) begin
			conc_q <= fin_conc;
			stat_q <= sat_q ? ST_ZERO_SMP : ST_OK;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			run_kind         <= cal_q;
			mean_resistance  <= avg_q;
			resistance_ratio <= ratio_q;
			concentration    <= conc_q;
			status           <= stat_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/gsp_checker.sv =====
// Port-level checks on the estimator's result channel, bound to the top level.
// Depends on gsp_pkg for the status codes.
`default_nettype none

module gsp_checker
	import gsp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        run_kind,
	input wire logic [31:0] resistance_ratio,
	input wire logic [31:0] concentration,
	input wire logic [1:0]  status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(concentration))
		else $error("result dropped or changed while stalled");

	a_cal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_kind |-> resistance_ratio == '0 && concentration == '0)
		else $error("calibration result carries ratio or concentration");

	a_no_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_CAL |->
			!run_kind && resistance_ratio == '0 && concentration == '0)
		else $error("uncalibrated result not cleared");

	a_bad_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_BASE |-> !run_kind && concentration == '0)
		else $error("non-positive base gave a concentration");

endmodule

bind gas_sensor_ppm_estimator_core gsp_checker u_gsp_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for gas_sensor_ppm_estimator_core: random and directed ADC samples,
// register writes between phases, and a scoreboard that predicts every finished run.
// Depends on gsp_pkg (port widths, register indexes, mode and status codes) and the core.
`default_nettype none

module tb_top;
	import gsp_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        kind;
		logic [31:0] mean;
		logic [31:0] ratio;
		logic [31:0] conc;
		logic [1:0]  st;
	} run_result_t;

	// The scoreboard keeps its own copy of the registers and of the run in progress.
	// It predicts the result of each run when the sample that ends the run is accepted.
	class ppm_scoreboard;
		bit [9:0]    n_avg;
		bit [15:0]   rl;
		bit [15:0]   car;
		bit [31:0]   ca;
		bit [15:0]   cb;
		bit [1:0]    mode;
		bit [63:0]   rsum;
		int unsigned cnt;
		bit          run_cal;
		bit          sat;
		bit [31:0]   ro;
		bit [31:0]   lg [0:LOG_TABLE_ENTRIES];
		bit [31:0]   ex [0:LOG_TABLE_ENTRIES];
		run_result_t pending[$];
		int          errors;

		function new();
			bit [31:0] m;
			bit [31:0] lo;
			bit [31:0] hi;
			bit [31:0] mid;
			bit [31:0] goal;
			n_avg = 100;
			rl = 256;
			car = 256;
			ca = 65536;
			cb = 4096;
			mode = MODE_GENERIC;
			rsum = 0;
			cnt = 0;
			run_cal = 0;
			sat = 0;
			ro = 0;
			errors = 0;
			for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
				m = 32'h4000_0000 + 32'((64'(i) << 30) / LOG_TABLE_ENTRIES);
				lg[i] = (log2_fraction(m, 18) + 32'd2) >> 2;
				goal = 32'((64'(i) << 24) / LOG_TABLE_ENTRIES);
				lo = 32'h4000_0000;
				hi = 32'h8000_0000;
				if (i < LOG_TABLE_ENTRIES) begin
					while (lo < hi) begin
						mid = lo + (hi - lo + 32'd1) / 2;
						if (log2_fraction(mid, 24) <= goal) lo = mid;
						else hi = mid - 32'd1;
					end
				end
				ex[i] = (i == LOG_TABLE_ENTRIES) ? hi : lo;
			end
		endfunction

		// Bits of log2 of a Q2.30 mantissa in [1,2], found by repeated squaring.
		function bit [31:0] log2_fraction(bit [31:0] m, int nbits);
			bit [63:0] y;
			bit [31:0] r;
			y = 64'(m);
			r = 0;
			if (m >= 32'h8000_0000) return 32'(64'd1 << nbits);
			for (int k = 0; k < nbits; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= 64'h8000_0000) begin
					y = y >> 1;
					r = r | 32'd1;
				end
			end
			return r;
		endfunction

		function longint floor_quot(longint p, longint d);
			if (p >= 0) return p / d;
			return -((-p + d - 1) / d);
		endfunction

		function int log2_q16(bit [31:0] x);
			int        p;
			bit [31:0] m;
			bit [63:0] t;
			bit [63:0] rem;
			bit [31:0] idx;
			bit [31:0] frac;
			p = 31;
			while (p > 0 && !x[p]) p--;
			m = x << (31 - p);
			t = 64'(m & 32'h7FFF_FFFF) * LOG_TABLE_ENTRIES;
			idx = 32'(t >> 31);
			rem = t & 64'h7FFF_FFFF;
			frac = lg[idx];
			if (lg[idx + 1] > lg[idx]) frac += 32'((64'(lg[idx + 1] - lg[idx]) * rem) >> 31);
			return (p - 16) * 65536 + int'(frac);
		endfunction

		// a * base^b / div, saturated to signed Q16.16.
		function bit [31:0] power_law(bit [31:0] base, bit [63:0] div);
			longint    a;
			longint    b;
			longint    e;
			longint    n;
			longint    s;
			bit [63:0] t;
			bit [63:0] idx;
			bit [63:0] mant;
			bit [63:0] mag_a;
			bit [63:0] prod;
			bit [63:0] v;
			a = longint'(signed'(ca));
			b = longint'(signed'(cb));
			e = floor_quot(longint'(log2_q16(base)) * b, 4096);
			n = floor_quot(e, 65536);
			t = 64'(e - n * 65536) * LOG_TABLE_ENTRIES;
			idx = t >> 16;
			mant = ex[idx];
			if (ex[idx + 1] > ex[idx]) mant += (64'(ex[idx + 1] - ex[idx]) * (t & 64'hFFFF)) >> 16;
			s = 30 - n;
			mag_a = a < 0 ? 64'(-a) : 64'(a);
			prod = mag_a * mant;
			if (s >= 64) v = 0;
			else if (s >= 0) v = prod >> s;
			else if (prod == 0) v = 0;
			else if (-s >= 62 || prod > (MAG_CAP >> (-s))) v = MAG_CAP;
			else v = prod << (-s);
			if (v > MAG_CAP) v = MAG_CAP;
			v = v / div;
			if (a < 0) begin
				if (v > 64'h8000_0000) v = 64'h8000_0000;
				return 32'(64'd0 - v);
			end
			if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
			return 32'(v);
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_SPA:  n_avg = data[9:0];
				REG_RL:   rl = data[15:0];
				REG_CAR:  car = data[15:0];
				REG_A:    ca = data;
				REG_B:    cb = data[15:0];
				REG_MODE: mode = data[1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic c, logic [SAMPLE_W-1:0] smp);
			bit [31:0]   nn;
			bit [63:0]   rs;
			bit [63:0]   avg;
			bit [63:0]   r;
			bit [63:0]   mag;
			bit [31:0]   base;
			bit [63:0]   div;
			int          lgv;
			bit          ok;
			run_result_t res;
			nn = n_avg ? 32'(n_avg) : 32'd1;
			if (cnt > 0 && c != run_cal) begin
				rsum = 0;
				cnt = 0;
				sat = 0;
			end
			if (cnt == 0) run_cal = c;
			if (smp == 0) begin
				rs = 64'hFFFF_FFFF;
				sat = 1;
			end else begin
				rs = 64'(rl) * 64'(ADC_FULL - smp) / 64'(smp);
				if (rs > 64'hFFFF_FFFF) rs = 64'hFFFF_FFFF;
			end
			rsum += rs;
			cnt++;
			if (cnt < (run_cal ? nn * nn : nn)) return;
			avg = rsum / cnt;
			res = '0;
			res.kind = run_cal;
			if (run_cal) begin
				r = (avg << 8) / (car ? 64'(car) : 64'd1);
				if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
				ro = 32'(r);
				avg = r;
				res.st = sat ? ST_ZERO_SMP : ST_OK;
			end else if (ro == 0) begin
				res.st = ST_NO_CAL;
			end else begin
				r = (avg << 16) / ro;
				if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
				res.ratio = 32'(r);
				ok = res.ratio != 0;
				base = res.ratio;
				if (ok && mode == MODE_CO2) begin
					lgv = log2_q16(res.ratio);
					mag = lgv > 0 ? (64'(lgv) * 64'(LOG10_2_Q32)) >> 32 : 64'd0;
					ok = mag > 0;
					base = 32'(mag);
				end
				if (!ok) begin
					res.st = ST_BAD_BASE;
				end else begin
					div = mode == MODE_CO ? 64'(DIVISOR_CO) :
						(mode == MODE_O3 ? 64'(DIVISOR_O3) : 64'd1);
					res.conc = power_law(base, div);
					res.st = sat ? ST_ZERO_SMP : ST_OK;
				end
			end
			res.mean = 32'(avg);
			pending.push_back(res);
			rsum = 0;
			cnt = 0;
			sat = 0;
		endfunction

		function void check_result(run_result_t got);
			run_result_t want;
			if (pending.size() == 0) begin
				$error("result with no run finished: kind %0d mean %h", got.kind, got.mean);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind) begin
				$error("run_kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.mean !== want.mean) begin
				$error("mean_resistance: expected %h, got %h", want.mean, got.mean);
				errors++;
			end
			if (got.ratio !== want.ratio) begin
				$error("resistance_ratio: expected %h, got %h", want.ratio, got.ratio);
				errors++;
			end
			if (got.conc !== want.conc) begin
				$error("concentration: expected %h, got %h", want.conc, got.conc);
				errors++;
			end
			if (got.st !== want.st) begin
				$error("status: expected %0d, got %0d", want.st, got.st);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic                run_kind;
	logic [31:0]         mean_resistance;
	logic [31:0]         resistance_ratio;
	logic signed [31:0]  concentration;
	logic [1:0]          status;

	ppm_scoreboard sb;
	int            cycles;
	int            sent;
	bit            calm;
	bit            hold_req;
	bit            hold_done;

	gas_sensor_ppm_estimator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.run_kind(run_kind), .mean_resistance(mean_resistance),
		.resistance_ratio(resistance_ratio), .concentration(concentration), .status(status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The cycle counter guards against a hung block; hitting the limit ends the run as a fail.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver side. Ready changes only at the falling edge. Once, on request, it holds off for
	// a long stretch that it counts itself, so the result register fills and the input stalls.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready = calm || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// Every result transfer is checked at the rising edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({run_kind, mean_resistance, resistance_ratio,
				concentration, status});
	end

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Registers change only while the block is idle. A sample that ends no run can still be in
	// flight after the last result, so a quiet stretch longer than one sample's work follows.
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic settle();
		wait_drained();
		repeat (100) @(posedge clk);
	endtask

	// One sample transfer. The sender may idle first; valid then stays high until accepted.
	task automatic send(logic c, logic [SAMPLE_W-1:0] smp);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 36) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		sample = smp;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(c, smp);
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 8) return ADC_FULL;
		if (r < 12) return SAMPLE_W'($urandom_range(1, 8));
		return SAMPLE_W'($urandom_range(1, 1023));
	endfunction

	// Picks register values for one phase; the first phases force the extremes.
	task automatic configure(int ph);
		logic [9:0]  n;
		logic [15:0] l;
		logic [15:0] c;
		logic [31:0] a;
		logic [15:0] b;
		logic [1:0]  md;
		n = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 6));
		l = 16'($urandom_range(1, 65535));
		c = 16'($urandom_range(1, 1024));
		a = $urandom;
		b = 16'($urandom_range(0, 65535));
		md = 2'($urandom_range(0, 3));
		if (ph == 0) begin
			n = 10'd1; l = 16'd1; c = 16'd1; a = 32'h8000_0000; b = 16'h8000; md = MODE_GENERIC;
		end else if (ph == 1) begin
			n = 10'd1023; l = 16'hFFFF; c = 16'hFFFF; a = 32'h7FFF_FFFF; b = 16'h7FFF;
			md = MODE_O3;
		end else if (ph == 2) begin
			n = 10'd2; l = 16'd0; c = 16'd0; a = 32'd0; b = 16'd0; md = MODE_CO;
		end else if (ph == 3) begin
			n = 10'd1;
		end
		write_reg(REG_SPA, 32'(n));
		write_reg(REG_RL, 32'(l));
		write_reg(REG_CAR, 32'(c));
		write_reg(REG_A, a);
		write_reg(REG_B, 32'(b));
		write_reg(REG_MODE, 32'(md));
	endtask

	initial begin
		int          ph;
		int          budget;
		int          start;
		int          r;
		int unsigned nn;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		sample = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: missing calibration, saturated and zero Ro, a zero sample,
		// a full-scale sample that gives a zero base, each gas mode and a run kind change.
		write_reg(REG_SPA, 32'd1);
		send(1'b0, 10'd512);
		send(1'b1, 10'd0);
		send(1'b1, 10'd1023);
		send(1'b0, 10'd700);
		send(1'b1, 10'd300);
		send(1'b0, 10'd300);
		send(1'b0, 10'd1023);
		send(1'b0, 10'd0);
		send(1'b0, 10'd1);
		send(1'b0, 10'd512);
		settle();
		write_reg(REG_MODE, 32'(MODE_CO2));
		send(1'b0, 10'd100);
		send(1'b0, 10'd900);
		send(1'b0, 10'd300);
		settle();
		write_reg(REG_MODE, 32'(MODE_CO));
		send(1'b0, 10'd200);
		settle();
		write_reg(REG_MODE, 32'(MODE_O3));
		send(1'b0, 10'd200);
		settle();
		write_reg(REG_SPA, 32'd2);
		write_reg(3'd6, 32'hFFFF_FFFF);
		send(1'b0, 10'd500);
		repeat (4) send(1'b1, 10'd400);
		send(1'b0, 10'd600);
		send(1'b0, 10'd600);

		// Random phases: mostly complete runs with random samples, some broken runs as noise.
		ph = 0;
		start = sent;
		while (sent - start < 1500) begin
			settle();
			configure(ph);
			nn = sb.n_avg ? sb.n_avg : 1;
			budget = (nn > 100) ? int'(nn) + 20 : 60;
			calm = (ph == 5);
			if (ph == 3) hold_req = 1'b1;
			r = sent;
			while (sent - r < budget) begin
				if (ph == 7 && sent - r == 30) wait_drained();
				case ($urandom_range(0, 99)) inside
					[0:19]: begin
						if (nn * nn <= 64) repeat (nn * nn) send(1'b1, rand_sample());
					end
					[20:84]: repeat (nn) send(1'b0, rand_sample());
					default: repeat ($urandom_range(1, 3)) send(1'($urandom_range(0, 1)),
						rand_sample());
				endcase
			end
			ph++;
		end

		calm = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
